/* sv/dlh_pkg.sv */
// Shared constants and types for the dual-lane 128-bit stream hash.
package dlh_pkg;

	// Lane start values and mixing constants
	localparam logic [63:0] LANE_A_START = 64'hcbf29ce484222325;
	localparam logic [63:0] LANE_B_START = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MUL_ONE   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MUL_TWO   = 64'h94d049bb133111eb;

	// Lane prime 0x100000001b3 split as 2^40 + 0x1b3
	localparam int unsigned LANE_PRIME_SHIFT = 40;
	localparam logic [8:0]  LANE_PRIME_LOW   = 9'h1b3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_LOW  = 2'd1;

	// Queue between front and back (depth must be a power of two)
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W = Q_PTR_W + 1;

	// Lane pair handed from the front to the finaliser
	typedef struct packed {
		logic [63:0] lane_a;
		logic [63:0] lane_b;
	} lanes_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* sv/dlh_fifo.sv */
// Short lane-pair queue that decouples the byte front end from the finaliser.
module dlh_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dlh_pkg::lanes_t   wdata,
	input  logic              pop,
	output dlh_pkg::lanes_t   rdata,
	output dlh_pkg::q_status_t status
);

	dlh_pkg::lanes_t                  mem_q [dlh_pkg::Q_DEPTH];
	logic [dlh_pkg::Q_PTR_W-1:0]      wr_ptr_q;
	logic [dlh_pkg::Q_PTR_W-1:0]      rd_ptr_q;
	logic [dlh_pkg::Q_CNT_W-1:0]      count_q;

	assign status.full  = (count_q == dlh_pkg::Q_CNT_W'(dlh_pkg::Q_DEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage carries payload only
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* sv/dlh_front.sv */
// Byte front end: seed registers, lane absorb and message framing.
module dlh_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dlh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_wdata,
	input  logic                          accept,
	input  logic [7:0]                    data_byte,
	input  logic                          byte_present,
	input  logic                          final_item,
	output logic                          push,
	output dlh_pkg::lanes_t               lanes
);

	logic [63:0] seed_high_q;
	logic [63:0] seed_low_q;
	logic [63:0] lane_a_q;
	logic [63:0] lane_b_q;
	logic        fresh_q;

	logic [63:0] base_a;
	logic [63:0] base_b;
	logic [63:0] next_a;
	logic [63:0] next_b;

	// XOR in the byte, rotate left by 8, multiply by the lane prime
	function automatic logic [63:0] absorb(input logic [63:0] lane, input logic [7:0] b);
		logic [63:0] t;
		logic [63:0] r;
		t = lane ^ {56'd0, b};
		r = {t[55:0], t[63:56]};
		return (r << dlh_pkg::LANE_PRIME_SHIFT) + (r * dlh_pkg::LANE_PRIME_LOW);
	endfunction

	always_comb begin
		base_a = fresh_q ? (dlh_pkg::LANE_A_START ^ seed_high_q) : lane_a_q;
		base_b = fresh_q ? (dlh_pkg::LANE_B_START ^ seed_low_q)  : lane_b_q;
		next_a = byte_present ? absorb(base_a, data_byte)  : base_a;
		next_b = byte_present ? absorb(base_b, ~data_byte) : base_b;
	end

	assign push         = accept && final_item;
	assign lanes.lane_a = next_a;
	assign lanes.lane_b = next_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_high_q <= '0;
			seed_low_q  <= '0;
			lane_a_q    <= '0;
			lane_b_q    <= '0;
			fresh_q     <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dlh_pkg::CFG_SEED_HIGH: seed_high_q <= cfg_wdata;
					dlh_pkg::CFG_SEED_LOW:  seed_low_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept && (byte_present || final_item)) begin
				if (final_item) begin
					// Lanes reload from the seeds at the next message start
					fresh_q <= 1'b1;
				end else begin
					lane_a_q <= next_a;
					lane_b_q <= next_b;
					fresh_q  <= 1'b0;
				end
			end
		end
	end

endmodule

/* sv/dlh_back.sv */
// Finaliser: three chained splitmix64 rounds on one shared 32x32 multiplier.
module dlh_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  dlh_pkg::lanes_t        q_data,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [127:0]           m_tdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_MUL
	} state_t;

	state_t       state_q;
	logic [1:0]   round_q;
	logic         pass_q;
	logic [1:0]   phase_q;
	logic [63:0]  la_q;
	logic [63:0]  lb_q;
	logic [63:0]  fa_q;
	logic [63:0]  fb_q;
	logic [63:0]  opnd_q;
	logic [63:0]  acc_q;
	logic         out_valid_q;
	logic [127:0] out_data_q;

	logic [63:0]  round_in;
	logic [63:0]  pre;
	logic [63:0]  pre_mix;
	logic [63:0]  k;
	logic [31:0]  mul_a;
	logic [31:0]  mul_b;
	logic [63:0]  prod;
	logic [63:0]  sum;
	logic [63:0]  mix27;
	logic [63:0]  fin;
	logic         out_free;
	logic         out_load;

	always_comb begin
		case (round_q)
			2'd0:    round_in = la_q ^ (la_q >> 32);
			2'd1:    round_in = lb_q ^ (lb_q >> 32) ^ fa_q;
			default: round_in = fb_q ^ (fb_q >> 32);
		endcase
		pre     = round_in + dlh_pkg::GOLDEN_GAMMA;
		pre_mix = pre ^ (pre >> 30);
		k       = pass_q ? dlh_pkg::SM_MUL_TWO : dlh_pkg::SM_MUL_ONE;
		// Partial products mod 2^64: lo*lo, lo*hi, hi*lo
		mul_a   = (phase_q == 2'd2) ? opnd_q[63:32] : opnd_q[31:0];
		mul_b   = (phase_q == 2'd1) ? k[63:32] : k[31:0];
		prod    = mul_a * mul_b;
		sum     = acc_q + {prod[31:0], 32'd0};
		mix27   = sum ^ (sum >> 27);
		fin     = sum ^ (sum >> 31);
	end

	assign out_free = !out_valid_q || m_tready;
	// Last partial product of the third round, with room in the output register
	assign out_load = (state_q == S_MUL) && pass_q && (phase_q == 2'd2) &&
		(round_q == 2'd2) && out_free;
	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			round_q     <= '0;
			pass_q      <= 1'b0;
			phase_q     <= '0;
			la_q        <= '0;
			lb_q        <= '0;
			fa_q        <= '0;
			fb_q        <= '0;
			opnd_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_load) begin
				out_data_q  <= {fb_q, fa_q ^ fin};
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						la_q    <= q_data.lane_a;
						lb_q    <= q_data.lane_b;
						round_q <= 2'd0;
						state_q <= S_START;
					end
				end
				S_START: begin
					opnd_q  <= pre_mix;
					pass_q  <= 1'b0;
					phase_q <= 2'd0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					case (phase_q)
						2'd0: begin
							acc_q   <= prod;
							phase_q <= 2'd1;
						end
						2'd1: begin
							acc_q   <= sum;
							phase_q <= 2'd2;
						end
						default: begin
							if (!pass_q) begin
								opnd_q  <= mix27;
								pass_q  <= 1'b1;
								phase_q <= 2'd0;
							end else begin
								case (round_q)
									2'd0: begin
										fa_q    <= fin;
										round_q <= 2'd1;
										state_q <= S_START;
									end
									2'd1: begin
										fb_q    <= fin;
										round_q <= 2'd2;
										state_q <= S_START;
									end
									default: begin
										// Hold until the output register is free
										if (out_free) begin
											state_q <= S_IDLE;
										end
									end
								endcase
							end
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* sv/dual_lane_hash128_stream_top.sv */
// Top level of the dual-lane 128-bit stream hash: front end, queue and finaliser.
// Throughput: one byte request per cycle in the front end while the queue has
// room (s_tready is low while it is full); the finaliser takes one message at a
// time, a pop and then three rounds on its single shared 32x32 multiplier, and
// pops the next one only after the previous hash is loaded into its output register.
// Reset: arst_n clears seeds to zero, empties the queue and idles the finaliser.
module dual_lane_hash128_stream_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port
	input  logic                          cfg_we,
	input  logic [dlh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_wdata,
	// Input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tuser,   // [0] byte_present
	input  logic                          s_tlast,   // final_item
	// Output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [127:0]                  m_tdata    // [63:0] hash_high, [127:64] hash_low
);

	logic               in_accept;
	logic               q_push;
	logic               q_pop;
	dlh_pkg::lanes_t    q_wdata;
	dlh_pkg::lanes_t    q_rdata;
	dlh_pkg::q_status_t q_status;

	// Stall new requests only while the queue holds no room for a finished message
	assign s_tready  = !q_status.full;
	assign in_accept = s_tvalid && s_tready;

	// Front end: absorb bytes into both lanes, hand finished lanes to the queue
	dlh_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.accept       (in_accept),
		.data_byte    (s_tdata),
		.byte_present (s_tuser),
		.final_item   (s_tlast),
		.push         (q_push),
		.lanes        (q_wdata)
	);

	// Queue: lets bytes of the next message advance while finalisation runs
	dlh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	// Finaliser with registered output request
	dlh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!q_status.empty),
		.q_data   (q_rdata),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Never push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_status.full)
		else $error("queue push while full");

	// Never pop an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_status.empty)
		else $error("queue pop while empty");

	// A push into an empty queue leaves it non-empty on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_status.empty) |=> !q_status.empty)
		else $error("pushed message lost");

endmodule
